### hw/rtl/okck_pkg.sv
// Shared types, constants and functions for the offset-keyed CRC keystream XOR core.
package okck_pkg;

   // Reflected CRC-32 polynomial
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;

   // Number of CRC byte stages (one per key byte)
   localparam int unsigned NUM_CRC_STAGES = 4;

   // Payload carried down the pipeline
   typedef struct packed {
      logic [31:0] crc;
      logic [7:0]  data;
      logic [1:0]  pos;
   } stage_type;

   // One reflected CRC-32 byte step, eight bit iterations
   function automatic logic [31:0] crc_byte_step(input logic [31:0] crc_in,
                                                 input logic [7:0]  byte_in);
      logic [31:0] crc;
      crc = crc_in ^ {24'h000000, byte_in};
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

   // Gather four 2-bit fields at 2p, 2p+8, 2p+16, 2p+24, first field on top
   function automatic logic [7:0] keystream_byte(input logic [31:0] state,
                                                 input logic [1:0]  pos);
      logic [31:0] sh;
      sh = state >> {pos, 1'b0};
      return {sh[1:0], sh[9:8], sh[17:16], sh[25:24]};
   endfunction

endpackage

### hw/rtl/okck_crc_stage.sv
// One pipeline stage: a CRC-32 byte step over one key byte, with its valid bit.
module okck_crc_stage
   import okck_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       in_valid,
   input  stage_type  in_data,
   input  logic [7:0] key_byte,
   output logic       out_valid,
   output stage_type  out_data
);

   logic      valid_ff;
   stage_type data_ff;
   stage_type data_in;

   // Apply this stage's CRC byte step
   always_comb begin
      data_in     = in_data;
      data_in.crc = crc_byte_step(in_data.crc, key_byte);
   end

   // Valid bit: cleared on reset, moves only when the stage advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // Payload: loaded only with a live request
   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

### hw/rtl/offset_keyed_crc_keystream_xor_core.sv
// Top level of the offset-keyed CRC keystream XOR core.
// Each request carries one data byte and its file offset; the response is the byte XORed
// with a keystream byte derived from a CRC-32 over the key, seeded by the inverted
// word-aligned offset. The core accepts one request per clock while req_stall is low and
// passes each through four CRC stages, one per key byte, then an output register that
// extracts the keystream byte and applies the XOR. Every stage advances
// on its own when the next one is empty or moving, so bubbles close up and a stalled
// output holds without loss. The key is written over the csr port, which is always
// ready; write it only while no request is in flight.
module offset_keyed_crc_keystream_xor_core
   import okck_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [31:0] req_byte_offset,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   // key register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_cipher_key
);

   logic [31:0] key_ff;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_out_byte_ff;
   logic [7:0]  rsp_out_byte_in;

   logic      stg_valid [NUM_CRC_STAGES+1];
   stage_type stg_data  [NUM_CRC_STAGES+1];
   logic      stg_adv   [NUM_CRC_STAGES+1];

   // Key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= 32'h00000000;
      end else if (csr_valid && csr_ready) begin
         key_ff <= csr_cipher_key;
      end
   end
   assign csr_ready = 1'b1;

   // Request into the pipeline: seed is the inverted word-aligned offset
   assign stg_valid[0] = req_valid;
   assign stg_data[0]  = {~{req_byte_offset[31:2], 2'b00}, req_data_byte,
                          req_byte_offset[1:0]};

   // Advance chain: a stage moves when the one after it is empty or moving
   always_comb begin
      stg_adv[NUM_CRC_STAGES] = !rsp_valid_ff || !rsp_stall;
      for (int i = NUM_CRC_STAGES - 1; i >= 0; i--) begin
         stg_adv[i] = !stg_valid[i+1] || stg_adv[i+1];
      end
   end
   assign req_stall = !stg_adv[0];

   // CRC byte stages, key low byte first
   for (genvar g = 0; g < NUM_CRC_STAGES; g++) begin : g_crc
      okck_crc_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (stg_adv[g]),
         .in_valid  (stg_valid[g]),
         .in_data   (stg_data[g]),
         .key_byte  (key_ff[8*g +: 8]),
         .out_valid (stg_valid[g+1]),
         .out_data  (stg_data[g+1])
      );
   end

   // Output stage: final inversion, field gather, XOR
   assign rsp_out_byte_in = stg_data[NUM_CRC_STAGES].data ^
                            keystream_byte(~stg_data[NUM_CRC_STAGES].crc,
                                           stg_data[NUM_CRC_STAGES].pos);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stg_adv[NUM_CRC_STAGES]) begin
         rsp_valid_ff <= stg_valid[NUM_CRC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (stg_adv[NUM_CRC_STAGES] && stg_valid[NUM_CRC_STAGES]) begin
         rsp_out_byte_ff <= rsp_out_byte_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_out_byte_ff;

   // Stall on the request side only when every stage holds a request
   a_stall_full : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid_ff && rsp_stall && stg_valid[1] && stg_valid[2] &&
                     stg_valid[3] && stg_valid[4]))
      else $error("request stalled with a free pipeline slot");

   // A blocked last CRC stage keeps its request
   a_last_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall && stg_valid[NUM_CRC_STAGES]) |=>
         (stg_valid[NUM_CRC_STAGES] && $stable(stg_data[NUM_CRC_STAGES])))
      else $error("last CRC stage lost or changed its request under stall");

   // A free output register accepts whatever the last stage holds
   a_out_fill : assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && stg_valid[NUM_CRC_STAGES]) |=> rsp_valid_ff)
      else $error("output register failed to take a ready request");

endmodule
